/* hw/rtl/tesd_pkg.sv */
package tesd_pkg;

  localparam int SUB_BITS    = 5;
  localparam int DEPTH_FRAC  = 12;
  localparam int COORD_WIDTH = 16;

  localparam int CW  = COORD_WIDTH;
  localparam int CW1 = CW + 1;
  localparam int CW2 = CW + 2;
  localparam int ZW  = 16;
  localparam int ZSW = ZW + 1;
  localparam int AW  = 2 * CW + 4;
  localparam int NW  = CW + 20;
  localparam int OW  = CW + 3;
  localparam int MW  = 2 * CW + 25;
  localparam int DVW = MW + DEPTH_FRAC;
  localparam int DW  = AW;
  localparam int QW  = 50;
  localparam int QW1 = QW + 1;
  localparam int RW  = 48;
  localparam int RW1 = RW + 1;

  localparam int SUBPIX      = 1 << SUB_BITS;
  localparam int HSUB        = SUBPIX / 2;
  localparam int GRAD_SHIFT  = SUB_BITS + DEPTH_FRAC + 1;
  localparam int START_SHIFT = DEPTH_FRAC + 1;

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  localparam logic [CW-1:0] FLOOR_MASK = ~CW'(SUBPIX - 1);
  localparam logic [RW:0]   SAT_MAG    = RW1'(1) << (RW - 1);
  localparam logic [RW-1:0] POS_MAX    = {1'b0, {(RW - 1){1'b1}}};
  localparam logic [RW-1:0] HALF_LSB   = RW'(1) << (DEPTH_FRAC - 1);

  typedef struct packed {
    logic [31:0]           edge_01;
    logic [31:0]           edge_20;
    logic [31:0]           edge_12;
    logic signed [AW-1:0]  area;
    logic signed [NW-1:0]  nx;
    logic signed [NW-1:0]  ny;
    logic signed [MW-1:0]  m2;
    logic [ZW-1:0]         z0;
    logic                  degen;
  } tesd_item_t;

  // Q is the quotient with one extra fraction bit; (Q+1)/2 rounds half up.
  function automatic logic [RW-1:0] round_sat(input logic [QW-1:0] q, input logic sat,
                                               input logic neg);
    logic [QW:0] r;
    logic [RW:0] mag;
    logic [RW:0] nmag;
    r = ({1'b0, q} + QW1'(1)) >> 1;
    if (sat || (r > QW1'(SAT_MAG))) begin
      mag = SAT_MAG;
    end else begin
      mag = r[RW:0];
    end
    nmag = RW1'(0) - mag;
    if (neg) begin
      return nmag[RW-1:0];
    end else if (mag == SAT_MAG) begin
      return POS_MAX;
    end else begin
      return mag[RW-1:0];
    end
  endfunction

endpackage

/* hw/rtl/tesd_front.sv */
module tesd_front
  import tesd_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             take,
  input  logic [15:0]      x0,
  input  logic [15:0]      y0,
  input  logic [15:0]      z0,
  input  logic [15:0]      x1,
  input  logic [15:0]      y1,
  input  logic [15:0]      z1,
  input  logic [15:0]      x2,
  input  logic [15:0]      y2,
  input  logic [15:0]      z2,
  output logic             push,
  output tesd_item_t       item
);

  logic [4:0] vld_r;

  // Stage 1 inputs: coordinates taken as signed values of the coordinate width.
  logic signed [CW-1:0] sx0, sy0, sx1, sy1, sx2, sy2, mx01, my01, mx, my;
  assign sx0  = $signed(x0[CW-1:0]);
  assign sy0  = $signed(y0[CW-1:0]);
  assign sx1  = $signed(x1[CW-1:0]);
  assign sy1  = $signed(y1[CW-1:0]);
  assign sx2  = $signed(x2[CW-1:0]);
  assign sy2  = $signed(y2[CW-1:0]);
  assign mx01 = (sx0 < sx1) ? sx0 : sx1;
  assign my01 = (sy0 < sy1) ? sy0 : sy1;
  assign mx   = (sx2 < mx01) ? sx2 : mx01;
  assign my   = (sy2 < my01) ? sy2 : my01;

  logic signed [CW-1:0]  x0_r, y0_r, x1_r, y1_r, x2_r, y2_r, bx_r, by_r;
  logic signed [ZSW-1:0] z0_r, z1_r, z2_r;

  // Stage 2: differences and products.
  logic signed [CW:0]   cx, cy, dx10, dy10, dx02, dy02, dx21, dy21, dy12, dy20;
  logic signed [CW+1:0] ex0, ey0, ex2, ey2, ex1, ey1;
  logic signed [ZSW:0]  dz12, dz20, dz01;
  logic signed [31:0]   pe0a, pe0b, pe1a, pe1b, pe2a, pe2b;
  logic signed [AW-1:0] pa0, pa1, pa2;
  logic signed [NW-1:0] pn0, pn1, pn2, pm0, pm1, pm2;
  logic signed [OW-1:0] dx2, dy2;

  assign cx   = CW1'(bx_r) + CW1'(HSUB);
  assign cy   = CW1'(by_r) + CW1'(HSUB);
  assign dx10 = x1_r - x0_r;
  assign dy10 = y1_r - y0_r;
  assign dx02 = x0_r - x2_r;
  assign dy02 = y0_r - y2_r;
  assign dx21 = x2_r - x1_r;
  assign dy21 = y2_r - y1_r;
  assign dy12 = y1_r - y2_r;
  assign dy20 = y2_r - y0_r;
  assign ex0  = cx - x0_r;
  assign ey0  = cy - y0_r;
  assign ex2  = cx - x2_r;
  assign ey2  = cy - y2_r;
  assign ex1  = cx - x1_r;
  assign ey1  = cy - y1_r;
  assign dz12 = z1_r - z2_r;
  assign dz20 = z2_r - z0_r;
  assign dz01 = z0_r - z1_r;
  assign pe0a = dx10 * ey0;
  assign pe0b = dy10 * ex0;
  assign pe1a = dx02 * ey2;
  assign pe1b = dy02 * ex2;
  assign pe2a = dx21 * ey1;
  assign pe2b = dy21 * ex1;
  assign pa0  = x0_r * dy12;
  assign pa1  = x1_r * dy20;
  assign pa2  = x2_r * (-dy10);
  assign pn0  = z0_r * dy12;
  assign pn1  = z1_r * dy20;
  assign pn2  = z2_r * (-dy10);
  assign pm0  = x0_r * dz12;
  assign pm1  = x1_r * dz20;
  assign pm2  = x2_r * dz01;
  assign dx2  = (OW'(bx_r) <<< 1) + OW'(SUBPIX) - (OW'(x0_r) <<< 1);
  assign dy2  = (OW'(by_r) <<< 1) + OW'(SUBPIX) - (OW'(y0_r) <<< 1);

  logic signed [31:0]    pe0a_r, pe0b_r, pe1a_r, pe1b_r, pe2a_r, pe2b_r;
  logic signed [AW-1:0]  pa0_r, pa1_r, pa2_r;
  logic signed [NW-1:0]  pn0_r, pn1_r, pn2_r, pm0_r, pm1_r, pm2_r;
  logic signed [OW-1:0]  dx2_r, dy2_r, dx2_s3_r, dy2_s3_r;
  logic signed [ZSW-1:0] z0_s2_r, z0_s3_r, z0_s4_r;

  // Stage 3: sums.
  logic [31:0]          e01_s3_r, e20_s3_r, e12_s3_r, e01_s4_r, e20_s4_r, e12_s4_r;
  logic signed [AW-1:0] area_s3_r, area_s4_r;
  logic signed [NW-1:0] nx_s3_r, ny_s3_r, nx_s4_r, ny_s4_r;

  // Stage 4: the start numerator's products.
  logic signed [MW-1:0] pz, pdx, pdy, pz_r, pdx_r, pdy_r;
  assign pz  = z0_s3_r * area_s3_r;
  assign pdx = nx_s3_r * dx2_s3_r;
  assign pdy = ny_s3_r * dy2_s3_r;

  logic degen_s4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[3:0], take};
    end
  end

  always_ff @(posedge clk) begin
    x0_r <= sx0;
    y0_r <= sy0;
    x1_r <= sx1;
    y1_r <= sy1;
    x2_r <= sx2;
    y2_r <= sy2;
    bx_r <= $signed(mx & FLOOR_MASK);
    by_r <= $signed(my & FLOOR_MASK);
    z0_r <= $signed({1'b0, z0});
    z1_r <= $signed({1'b0, z1});
    z2_r <= $signed({1'b0, z2});

    pe0a_r  <= pe0a;
    pe0b_r  <= pe0b;
    pe1a_r  <= pe1a;
    pe1b_r  <= pe1b;
    pe2a_r  <= pe2a;
    pe2b_r  <= pe2b;
    pa0_r   <= pa0;
    pa1_r   <= pa1;
    pa2_r   <= pa2;
    pn0_r   <= pn0;
    pn1_r   <= pn1;
    pn2_r   <= pn2;
    pm0_r   <= pm0;
    pm1_r   <= pm1;
    pm2_r   <= pm2;
    dx2_r   <= dx2;
    dy2_r   <= dy2;
    z0_s2_r <= z0_r;

    e01_s3_r  <= pe0a_r - pe0b_r;
    e20_s3_r  <= pe1a_r - pe1b_r;
    e12_s3_r  <= pe2a_r - pe2b_r;
    area_s3_r <= pa0_r + pa1_r + pa2_r;
    nx_s3_r   <= pn0_r + pn1_r + pn2_r;
    ny_s3_r   <= pm0_r + pm1_r + pm2_r;
    dx2_s3_r  <= dx2_r;
    dy2_s3_r  <= dy2_r;
    z0_s3_r   <= z0_s2_r;

    pz_r       <= pz;
    pdx_r      <= pdx;
    pdy_r      <= pdy;
    e01_s4_r   <= e01_s3_r;
    e20_s4_r   <= e20_s3_r;
    e12_s4_r   <= e12_s3_r;
    area_s4_r  <= area_s3_r;
    nx_s4_r    <= nx_s3_r;
    ny_s4_r    <= ny_s3_r;
    z0_s4_r    <= z0_s3_r;
    degen_s4_r <= (area_s3_r == '0);

    item.edge_01 <= e01_s4_r;
    item.edge_20 <= e20_s4_r;
    item.edge_12 <= e12_s4_r;
    item.area    <= area_s4_r;
    item.nx      <= nx_s4_r;
    item.ny      <= ny_s4_r;
    item.m2      <= (pz_r <<< 1) + pdx_r + pdy_r;
    item.z0      <= z0_s4_r[ZW-1:0];
    item.degen   <= degen_s4_r;
  end

  assign push = vld_r[4];

endmodule

/* hw/rtl/tesd_queue.sv */
module tesd_queue
  import tesd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  tesd_item_t item_in,
  input  logic       pop,
  output logic       valid,
  output tesd_item_t item_out
);

  tesd_item_t      mem_r [QDEPTH];
  logic [QAW-1:0]  wr_r, rd_r;
  logic [QCW-1:0]  cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wr_r <= wr_r + QAW'(1);
      end
      if (pop) begin
        rd_r <= rd_r + QAW'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + QCW'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - QCW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= item_in;
    end
  end

  assign valid    = (cnt_r != '0);
  assign item_out = mem_r[rd_r];

endmodule

/* hw/rtl/tesd_div.sv */
module tesd_div
  import tesd_pkg::*;
(
  input  logic           clk,
  input  logic           rst_n,
  input  logic           go,
  input  logic [DVW-1:0] dvd,
  input  logic [DW-1:0]  dvs,
  output logic           done,
  output logic [QW-1:0]  q,
  output logic           sat
);

  localparam int CNTW = $clog2(DVW + 1);

  logic [CNTW-1:0] cnt_r;
  logic            run_r, done_r, sat_r;
  logic [DW-1:0]   rem_r, dvs_r;
  logic [DVW-1:0]  dvd_r;
  logic [QW-1:0]   q_r;
  logic [DW:0]     r2;
  logic            ge;

  // Restoring division, one quotient bit per cycle.
  assign r2 = {rem_r, dvd_r[DVW-1]};
  assign ge = (r2 >= {1'b0, dvs_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        run_r <= 1'b1;
        cnt_r <= CNTW'(DVW);
      end else if (run_r) begin
        cnt_r <= cnt_r - CNTW'(1);
        if (cnt_r == CNTW'(1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      rem_r <= '0;
      dvd_r <= dvd;
      dvs_r <= dvs;
      q_r   <= '0;
      sat_r <= 1'b0;
    end else if (run_r) begin
      rem_r <= ge ? DW'(r2 - {1'b0, dvs_r}) : r2[DW-1:0];
      dvd_r <= dvd_r << 1;
      q_r   <= {q_r[QW-2:0], ge};
      sat_r <= sat_r | q_r[QW-1];
    end
  end

  assign done = done_r;
  assign q    = q_r;
  assign sat  = sat_r | q_r[QW-1];

endmodule

/* hw/rtl/tesd_back.sv */
module tesd_back
  import tesd_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_valid,
  input  tesd_item_t       q_item,
  output logic             q_pop,
  output logic             out_valid,
  output logic [31:0]      out_edge_01,
  output logic [31:0]      out_edge_20,
  output logic [31:0]      out_edge_12,
  output logic [RW-1:0]    out_depth_dx,
  output logic [RW-1:0]    out_depth_dy,
  output logic [RW-1:0]    out_depth_start,
  output logic             out_degenerate
);

  typedef enum logic {B_IDLE, B_RUN} bstate_t;

  bstate_t state_r;

  logic [AW-1:0]  area_mag;
  logic [NW-1:0]  nx_mag, ny_mag;
  logic [MW-1:0]  m2_mag;
  logic [DVW-1:0] dvd_x, dvd_y, dvd_s;
  logic [DW-1:0]  dvs_g, dvs_s;
  logic           go;

  assign area_mag = q_item.area[AW-1] ? AW'(-q_item.area) : AW'(q_item.area);
  assign nx_mag   = q_item.nx[NW-1] ? NW'(-q_item.nx) : NW'(q_item.nx);
  assign ny_mag   = q_item.ny[NW-1] ? NW'(-q_item.ny) : NW'(q_item.ny);
  assign m2_mag   = q_item.m2[MW-1] ? MW'(-q_item.m2) : MW'(q_item.m2);
  assign dvd_x    = DVW'(nx_mag) << GRAD_SHIFT;
  assign dvd_y    = DVW'(ny_mag) << GRAD_SHIFT;
  assign dvd_s    = DVW'(m2_mag) << START_SHIFT;
  assign dvs_g    = area_mag;
  assign dvs_s    = {area_mag[AW-2:0], 1'b0};

  assign go    = (state_r == B_IDLE) && q_valid;
  assign q_pop = go;

  logic          done_x, done_y, done_s, sat_x, sat_y, sat_s;
  logic [QW-1:0] qx, qy, qs;

  tesd_div u_div_x (.clk, .rst_n, .go, .dvd(dvd_x), .dvs(dvs_g),
                    .done(done_x), .q(qx), .sat(sat_x));
  tesd_div u_div_y (.clk, .rst_n, .go, .dvd(dvd_y), .dvs(dvs_g),
                    .done(done_y), .q(qy), .sat(sat_y));
  tesd_div u_div_s (.clk, .rst_n, .go, .dvd(dvd_s), .dvs(dvs_s),
                    .done(done_s), .q(qs), .sat(sat_s));

  logic [31:0]   e01_r, e20_r, e12_r;
  logic [ZW-1:0] z0_r;
  logic          degen_r, neg_x_r, neg_y_r, neg_s_r;

  always_ff @(posedge clk) begin
    if (go) begin
      e01_r   <= q_item.edge_01;
      e20_r   <= q_item.edge_20;
      e12_r   <= q_item.edge_12;
      z0_r    <= q_item.z0;
      degen_r <= q_item.degen;
      neg_x_r <= q_item.nx[NW-1] ^ q_item.area[AW-1];
      neg_y_r <= q_item.ny[NW-1] ^ q_item.area[AW-1];
      neg_s_r <= q_item.m2[MW-1] ^ q_item.area[AW-1];
    end
  end

  logic [RW-1:0] rx, ry, rs, flat;
  logic [RW:0]   sum_s;
  logic          all_done;

  assign rx       = round_sat(qx, sat_x, neg_x_r);
  assign ry       = round_sat(qy, sat_y, neg_y_r);
  assign rs       = round_sat(qs, sat_s, neg_s_r);
  assign sum_s    = {rs[RW-1], rs} + {1'b0, HALF_LSB};
  assign flat     = (RW'(z0_r) << DEPTH_FRAC) | HALF_LSB;
  assign all_done = done_x & done_y & done_s;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= B_IDLE;
      out_valid <= 1'b0;
    end else begin
      out_valid <= 1'b0;
      case (state_r)
        B_IDLE: begin
          if (q_valid) begin
            state_r <= B_RUN;
          end
        end
        B_RUN: begin
          if (all_done) begin
            state_r   <= B_IDLE;
            out_valid <= 1'b1;
          end
        end
        default: state_r <= B_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == B_RUN) && all_done) begin
      out_edge_01    <= e01_r;
      out_edge_20    <= e20_r;
      out_edge_12    <= e12_r;
      out_degenerate <= degen_r;
      if (degen_r) begin
        out_depth_dx    <= '0;
        out_depth_dy    <= '0;
        out_depth_start <= flat;
      end else begin
        out_depth_dx    <= rx;
        out_depth_dy    <= ry;
        out_depth_start <= (sum_s[RW] != sum_s[RW-1]) ? POS_MAX : sum_s[RW-1:0];
      end
    end
  end

endmodule

/* hw/rtl/triangle_edge_depth_setup.sv */
// Channel   Handshake            Payload
// input     start / busy         in_v0_x .. in_v2_z, one triangle per beat
// result    out_valid (strobe)   out_edge_*, out_depth_*, out_degenerate
//
// A triangle is taken at a clock edge where start is high and busy is low.
// The front pipeline forms the edge values, area and plane numerators;
// the back end then runs three bit-serial dividers, one quotient bit per
// cycle over the full numerator width (69 bits here). The result register
// loads in the cycle after the last quotient bit, and only then does the
// next queued triangle leave the queue, so the back end works on one
// triangle at a time. Up to four triangles may be accepted back to back.
// Reset is synchronous and active low; it empties the pipeline and queue.
// out_valid is high for a single cycle per result; the out ports hold
// that result until the next one loads.
module triangle_edge_depth_setup
  import tesd_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] in_v0_x,
  input  logic signed [15:0] in_v0_y,
  input  logic [15:0]        in_v0_z,
  input  logic signed [15:0] in_v1_x,
  input  logic signed [15:0] in_v1_y,
  input  logic [15:0]        in_v1_z,
  input  logic signed [15:0] in_v2_x,
  input  logic signed [15:0] in_v2_y,
  input  logic [15:0]        in_v2_z,
  output logic               out_valid,
  output logic signed [31:0] out_edge_01,
  output logic signed [31:0] out_edge_20,
  output logic signed [31:0] out_edge_12,
  output logic signed [47:0] out_depth_dx,
  output logic signed [47:0] out_depth_dy,
  output logic signed [47:0] out_depth_start,
  output logic               out_degenerate
);

  // Triangles in the front pipeline plus those waiting in the queue never
  // exceed the queue depth, so the front never has to stall.
  logic [QCW-1:0] occ_r;
  logic           accept;
  logic           push, pop, q_valid;
  tesd_item_t     f_item, q_item;

  assign busy   = (occ_r == QCW'(QDEPTH));
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= '0;
    end else if (accept && !pop) begin
      occ_r <= occ_r + QCW'(1);
    end else if (pop && !accept) begin
      occ_r <= occ_r - QCW'(1);
    end
  end

  tesd_front u_front (
    .clk, .rst_n, .take(accept),
    .x0(in_v0_x), .y0(in_v0_y), .z0(in_v0_z),
    .x1(in_v1_x), .y1(in_v1_y), .z1(in_v1_z),
    .x2(in_v2_x), .y2(in_v2_y), .z2(in_v2_z),
    .push, .item(f_item)
  );

  tesd_queue u_queue (
    .clk, .rst_n, .push, .item_in(f_item), .pop,
    .valid(q_valid), .item_out(q_item)
  );

  tesd_back u_back (
    .clk, .rst_n, .q_valid, .q_item, .q_pop(pop),
    .out_valid, .out_edge_01, .out_edge_20, .out_edge_12,
    .out_depth_dx, .out_depth_dy, .out_depth_start, .out_degenerate
  );

  // The occupancy count never passes the queue depth.
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= QCW'(QDEPTH)) else $error("occupancy overflow");

  // A degenerate triangle always reports flat gradients.
  a_degen_flat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_degenerate |-> out_depth_dx == '0 && out_depth_dy == '0)
    else $error("degenerate triangle with nonzero gradient");

  // Results come from a serial back end and are never in adjacent cycles.
  a_strobe_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobes back to back");

  // An accepted triangle without a pop raises the occupancy by one.
  a_occ_inc: assert property (@(posedge clk) disable iff (!rst_n)
    accept && !pop |=> occ_r == $past(occ_r) + QCW'(1))
    else $error("occupancy not counted");

endmodule
